>>> hw/rtl/rhc_pkg.sv
// shared types, constants and trig table for the rgb to hsv converter
`default_nettype none
package rhc_pkg;

  // fractional bits of the trig table
  localparam int TrigFracBits = 16;
  localparam real Pi = 3.14159265358979323846;

  // table entry holds 0 .. 2^f, the signed value needs one more bit
  typedef logic [TrigFracBits:0] sin_ent_t;
  typedef logic signed [TrigFracBits+1:0] trig_t;
  typedef sin_ent_t sin_tab_t [91];

  function automatic sin_tab_t build_sin_table();
    sin_tab_t tab;
    real x;
    for (int d = 0; d <= 90; d++) begin
      x = $sin(d * Pi / 180.0) * (2.0 ** TrigFracBits);
      tab[d] = sin_ent_t'($rtoi(x + 0.5));
    end
    return tab;
  endfunction

  localparam sin_tab_t SinTable = build_sin_table();

  // signed sine of a whole degree angle 0..449
  function automatic trig_t sin_deg(logic [9:0] d);
    logic [9:0] a;
    logic [9:0] idx;
    logic       neg;
    a = (d >= 10'd360) ? d - 10'd360 : d;
    neg = 1'b0;
    if (a <= 10'd90) begin
      idx = a;
    end else if (a <= 10'd180) begin
      idx = 10'd180 - a;
    end else if (a <= 10'd270) begin
      idx = a - 10'd180;
      neg = 1'b1;
    end else begin
      idx = 10'd360 - a;
      neg = 1'b1;
    end
    if (neg) begin
      return -trig_t'({1'b0, SinTable[idx[6:0]]});
    end
    return trig_t'({1'b0, SinTable[idx[6:0]]});
  endfunction

  // one pixel in flight through the divider chain
  typedef struct packed {
    logic        valid;
    logic        gray;
    logic [7:0]  bright;
    logic [16:0] rem_h;
    logic [16:0] dsh_h;
    logic [8:0]  quo_h;
    logic [16:0] rem_s;
    logic [16:0] dsh_s;
    logic [8:0]  quo_s;
  } div_t;

endpackage
`default_nettype wire

>>> hw/rtl/rhc_if.sv
// stream interfaces for pixels in and hsv results out
`default_nettype none
interface rhc_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface rhc_hsv_if;
  logic       valid;
  logic       ready;
  logic [8:0] hue;
  logic [7:0] saturation;
  logic [7:0] brightness;
  logic [8:0] chroma_x;
  logic [8:0] chroma_y;
  modport source (output valid, output hue, output saturation, output brightness,
                  output chroma_x, output chroma_y, input ready);
  modport sink (input valid, input hue, input saturation, input brightness,
                input chroma_x, input chroma_y, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/rhc_div_cell.sv
// one restoring division step for hue and saturation
`default_nettype none
module rhc_div_cell (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         en_i,
  input  wire rhc_pkg::div_t cell_i,
  output rhc_pkg::div_t     cell_o
);

  rhc_pkg::div_t cell_d, cell_q;

  always_comb begin
    cell_d = cell_i;
    if (cell_i.rem_h >= cell_i.dsh_h) begin
      cell_d.rem_h = cell_i.rem_h - cell_i.dsh_h;
      cell_d.quo_h = {cell_i.quo_h[7:0], 1'b1};
    end else begin
      cell_d.quo_h = {cell_i.quo_h[7:0], 1'b0};
    end
    if (cell_i.rem_s >= cell_i.dsh_s) begin
      cell_d.rem_s = cell_i.rem_s - cell_i.dsh_s;
      cell_d.quo_s = {cell_i.quo_s[7:0], 1'b1};
    end else begin
      cell_d.quo_s = {cell_i.quo_s[7:0], 1'b0};
    end
    cell_d.dsh_h = cell_i.dsh_h >> 1;
    cell_d.dsh_s = cell_i.dsh_s >> 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule
`default_nettype wire

>>> hw/rtl/rgb_to_hsv_with_chroma_xy.sv
// top level: rgb pixel to hsv with chroma plane point
// a pixel passes the setup register, the divider cells and the output register in turn
// throughput: one pixel per cycle while the output is not stalled, set by the 9-cell restoring divider chain
// each pipeline stage moves on when it is empty or its successor moves, so
// bubbles collapse and input is taken while a result waits
// reset: asynchronous active low, clears all stage valid bits
`default_nettype none
module rgb_to_hsv_with_chroma_xy (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rhc_pix_if.sink   pix_i,
  rhc_hsv_if.source hsv_o
);

  localparam int NumCells = 9;
  localparam int F = rhc_pkg::TrigFracBits;

  // stage 0 is the setup register, stages 1..9 are divider cells
  rhc_pkg::div_t stage [NumCells+1];
  logic [NumCells+1:0] en;

  // output register
  logic       out_v_q;
  logic [8:0] hue_q;
  logic [7:0] sat_q;
  logic [7:0] bri_q;
  logic [8:0] cx_q;
  logic [8:0] cy_q;

  // enable ripple from the output back to the input
  always_comb begin
    en[NumCells+1] = !out_v_q || hsv_o.ready;
    for (int k = NumCells; k >= 0; k--) begin
      en[k] = !stage[k].valid || en[k+1];
    end
  end

  assign pix_i.ready = en[0];

  // setup: max, min, range, sector numerator
  logic [7:0] mx, mn, delta;
  logic signed [17:0] num;
  rhc_pkg::div_t setup_d, setup_q;

  always_comb begin
    logic signed [17:0] r, g, b, d;
    r = 18'(pix_i.red);
    g = 18'(pix_i.green);
    b = 18'(pix_i.blue);
    mx = (pix_i.red > pix_i.green) ? pix_i.red : pix_i.green;
    if (pix_i.blue > mx) mx = pix_i.blue;
    mn = (pix_i.red < pix_i.green) ? pix_i.red : pix_i.green;
    if (pix_i.blue < mn) mn = pix_i.blue;
    delta = mx - mn;
    d = 18'(delta);
    // sector ties go red, then green, then blue
    if (pix_i.red == mx) begin
      num = 18'sd60 * (g - b);
    end else if (pix_i.green == mx) begin
      num = 18'sd120 * d + 18'sd60 * (b - r);
    end else begin
      num = 18'sd240 * d + 18'sd60 * (r - g);
    end
    // negative hue wraps around
    if (num < 0) num = num + 18'sd360 * d;

    setup_d.valid  = pix_i.valid;
    setup_d.gray   = (delta == 8'd0);
    setup_d.bright = mx;
    setup_d.rem_h  = num[16:0];
    setup_d.dsh_h  = {1'b0, delta, 8'd0};
    setup_d.quo_h  = '0;
    // 255 * range
    setup_d.rem_s  = {1'b0, delta, 8'd0} - 17'(delta);
    setup_d.dsh_s  = {1'b0, mx, 8'd0};
    setup_d.quo_s  = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setup_q <= '0;
    end else if (en[0]) begin
      setup_q <= setup_d;
    end
  end

  assign stage[0] = setup_q;

  // divider chain, one quotient bit per cell
  for (genvar k = 1; k <= NumCells; k++) begin : g_cell
    rhc_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en[k]),
      .cell_i (stage[k-1]),
      .cell_o (stage[k])
    );
  end

  // chroma: floor((sat * trig + 255 * 2^f) / 2^f), clamped at zero
  function automatic logic [8:0] chroma(logic [7:0] sat, rhc_pkg::trig_t trig);
    logic signed [F+10:0] s_ext, t_ext, sum;
    s_ext = {{(F+3){1'b0}}, sat};
    t_ext = {{9{trig[F+1]}}, trig};
    sum = s_ext * t_ext + ((F+11)'(255) <<< F);
    if (sum[F+10]) return 9'd0;
    return sum[F+8:F];
  endfunction

  // final stage: gray masking, trig lookup and chroma point
  logic [8:0] hue_w;
  logic [7:0] sat_w;

  always_comb begin
    rhc_pkg::div_t last;
    last = stage[NumCells];
    if (last.gray || last.quo_h >= 9'd360) hue_w = 9'd0;
    else hue_w = last.quo_h;
    sat_w = last.gray ? 8'd0 : last.quo_s[7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en[NumCells+1]) begin
      out_v_q <= stage[NumCells].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NumCells+1]) begin
      hue_q <= hue_w;
      sat_q <= sat_w;
      bri_q <= stage[NumCells].bright;
      cx_q  <= chroma(sat_w, rhc_pkg::sin_deg(10'(hue_w) + 10'd90));
      cy_q  <= chroma(sat_w, rhc_pkg::sin_deg(10'(hue_w)));
    end
  end

  assign hsv_o.valid      = out_v_q;
  assign hsv_o.hue        = hue_q;
  assign hsv_o.saturation = sat_q;
  assign hsv_o.brightness = bri_q;
  assign hsv_o.chroma_x   = cx_q;
  assign hsv_o.chroma_y   = cy_q;

endmodule
`default_nettype wire

>>> tb/tb_rgb_to_hsv_with_chroma_xy.sv
// testbench for the rgb to hsv converter with chroma plane point
`timescale 1ns / 1ps
`default_nettype none
module tb_rgb_to_hsv_with_chroma_xy;

  // one expected hsv result
  typedef struct {
    logic [8:0] hue;
    logic [7:0] sat;
    logic [7:0] bright;
    logic [8:0] cx;
    logic [8:0] cy;
  } hsv_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #6 clk_i = ~clk_i;

  rhc_pix_if pix ();
  rhc_hsv_if hsv ();

  rgb_to_hsv_with_chroma_xy dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix.sink),
    .hsv_o  (hsv.source)
  );

  hsv_t   hsv_pending[$];
  int     mismatches = 0;
  int     pixels_sent = 0;
  int     results_seen = 0;
  int     cycle_count = 0;
  bit     calm = 1'b0;      // no idling on either side while set
  longint sine_q[91];

  // sine table in q1.16, rounded to nearest, built from a series in real math
  function automatic void build_sines();
    real x, t, s;
    for (int d = 0; d <= 90; d++) begin
      x = d * 3.14159265358979323846 / 180.0;
      t = x;
      s = x;
      for (int k = 1; k <= 20; k++) begin
        t = -t * x * x / ((2 * k) * (2 * k + 1));
        s = s + t;
      end
      if (s < 0.0) s = 0.0;
      sine_q[d] = longint'($floor(s * 65536.0 + 0.5));
    end
  endfunction

  function automatic longint sine_of(int d);
    d = d % 360;
    if (d <= 90) return sine_q[d];
    if (d <= 180) return sine_q[180 - d];
    if (d <= 270) return -sine_q[d - 180];
    return -sine_q[360 - d];
  endfunction

  function automatic logic [8:0] chroma_axis(int sat, longint trig);
    longint sum;
    sum = sat * trig + (longint'(255) << 16);
    if (sum < 0) sum = 0;
    return 9'(sum >> 16);
  endfunction

  function automatic hsv_t pixel_to_hsv(logic [7:0] r8, logic [7:0] g8, logic [7:0] b8);
    hsv_t h;
    int r, g, b, mx, mn, delta, num, hue, sat;
    r = r8; g = g8; b = b8;
    mx = (r > g) ? r : g;
    if (b > mx) mx = b;
    mn = (r < g) ? r : g;
    if (b < mn) mn = b;
    delta = mx - mn;
    hue = 0;
    sat = 0;
    if (delta != 0) begin
      sat = (255 * delta) / mx;
      // sector ties go red, then green, then blue
      if (r == mx) num = 60 * (g - b);
      else if (g == mx) num = 120 * delta + 60 * (b - r);
      else num = 240 * delta + 60 * (r - g);
      if (num < 0) num += 360 * delta;
      hue = num / delta;
      if (hue >= 360) hue = 0;
    end
    h.hue = 9'(hue);
    h.sat = 8'(sat);
    h.bright = 8'(mx);
    h.cx = chroma_axis(sat, sine_of(hue + 90));
    h.cy = chroma_axis(sat, sine_of(hue));
    return h;
  endfunction

  // send one pixel, optionally idling first
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while (!calm && $urandom_range(99) < 34) begin
      pix.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix.valid <= 1'b1;
    pix.red   <= r;
    pix.green <= g;
    pix.blue  <= b;
    @(posedge clk_i);
    while (!pix.ready) @(posedge clk_i);
    hsv_pending.push_back(pixel_to_hsv(r, g, b));
    pixels_sent++;
  endtask

  // sink side: random stalls on ready
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    hsv.ready <= calm ? 1'b1 : ($urandom_range(99) >= 34);
  end

  // result checker
  always @(posedge clk_i) begin
    hsv_t e;
    if (rst_ni && hsv.valid && hsv.ready) begin
      results_seen++;
      if (hsv_pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction at cycle %0d", cycle_count);
      end else begin
        e = hsv_pending.pop_front();
        if (hsv.hue !== e.hue || hsv.saturation !== e.sat || hsv.brightness !== e.bright ||
            hsv.chroma_x !== e.cx || hsv.chroma_y !== e.cy) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp h=%0d s=%0d v=%0d x=%0d y=%0d got h=%0d s=%0d v=%0d x=%0d y=%0d",
                     e.hue, e.sat, e.bright, e.cx, e.cy, hsv.hue, hsv.saturation,
                     hsv.brightness, hsv.chroma_x, hsv.chroma_y);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (cycle_count > 200000) begin
      $display("timeout with %0d transactions outstanding", hsv_pending.size());
      $display("** rgb_to_hsv_with_chroma_xy: FAILED **");
      $finish;
    end
  end

  // extremes, gray pixels and every sector tie
  task automatic test_directed();
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);   // red and green tie
    send_pixel(8'd0, 8'd255, 8'd255);   // green and blue tie
    send_pixel(8'd255, 8'd0, 8'd255);   // red and blue tie
    send_pixel(8'd255, 8'd0, 8'd1);     // hue wraps just below 360
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd1, 8'd1, 8'd0);
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd170, 8'd85, 8'd0);
    send_pixel(8'd0, 8'd170, 8'd85);
    send_pixel(8'd85, 8'd0, 8'd170);
    send_pixel(8'd200, 8'd100, 8'd150);
  endtask

  // random pixels, one in four forced gray or tied
  task automatic test_random(int count);
    logic [7:0] r, g, b;
    for (int i = 0; i < count; i++) begin
      r = 8'($urandom);
      g = 8'($urandom);
      b = 8'($urandom);
      case ($urandom_range(15))
        0: begin g = r; b = r; end
        1: g = r;
        2: b = g;
        3: b = r;
        default: ;
      endcase
      send_pixel(r, g, b);
    end
  endtask

  // back-to-back stretch with both sides never idling
  task automatic test_full_rate(int count);
    calm = 1'b1;
    test_random(count);
    calm = 1'b0;
  endtask

  initial begin
    pix.valid = 1'b0;
    pix.red = '0;
    pix.green = '0;
    pix.blue = '0;
    build_sines();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(900);
    test_full_rate(300);
    test_random(700);
    pix.valid <= 1'b0;
    while (hsv_pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("sent %0d pixels incl. gray, tie and wrap cases; checked %0d results",
             pixels_sent, results_seen);
    if (mismatches == 0) begin
      $display("** rgb_to_hsv_with_chroma_xy: PASSED **");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("** rgb_to_hsv_with_chroma_xy: FAILED **");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> rgb_to_hsv_with_chroma_xy.f
hw/rtl/rhc_pkg.sv
hw/rtl/rhc_if.sv
hw/rtl/rhc_div_cell.sv
hw/rtl/rgb_to_hsv_with_chroma_xy.sv
tb/tb_rgb_to_hsv_with_chroma_xy.sv
